### rtl/pdq_pkg.sv
package pdq_pkg;

  // Sample format and limits
  localparam int unsigned SAMPLE_FRAC_BITS_DEF = 27;
  localparam logic [31:0] RIFF_DATA_LIMIT      = 32'd4294967259;
  localparam logic [31:0] NOISE_SEED           = 32'h9e3779b9;

  // PCM full-scale multipliers
  localparam logic [22:0] SCALE_16 = 23'd32767;
  localparam logic [22:0] SCALE_24 = 23'd8388607;

  // Data bytes per stereo frame
  localparam logic [2:0] FRAME_BYTES_16 = 3'd4;
  localparam logic [2:0] FRAME_BYTES_24 = 3'd6;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DITHER_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 2'd2;

  // Reset values of the registers
  localparam logic        SAMPLE_FORMAT_RST = 1'b1;
  localparam logic        DITHER_ENABLE_RST = 1'b0;
  localparam logic [23:0] GAIN_RST          = 24'd65536;

  typedef struct packed {
    logic signed [31:0] left_sample;
    logic signed [31:0] right_sample;
    logic               last_in_block;
  } in_t;

  typedef struct packed {
    logic signed [23:0] left_code;
    logic signed [23:0] right_code;
    logic               size_overflow;
    logic [31:0]        bytes_total;
    logic               last_out;
  } out_t;

  typedef struct packed {
    logic        sample_format;
    logic        dither_enable;
    logic [23:0] gain;
  } cfg_t;

  // Controller to datapath strobes
  typedef struct packed {
    logic load;
    logic mul;
    logic sat;
    logic add;
    logic plo;
    logic phi;
    logic sum;
    logic rnd;
    logic fin;
    logic side;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // One xorshift32 step
  function automatic logic [31:0] xs32(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage

### rtl/pcm_dither_quantizer.sv
// Stereo PCM quantizer: each transaction carries one frame of signed fixed-point
// samples; the left and right samples are each multiplied by the gain, optionally
// dithered with triangular noise from an xorshift32 generator, clamped to full
// scale and rounded half to even into 16- or 24-bit codes. A running data byte
// count refuses frames that would take the total past the RIFF limit; a refused
// frame returns zero codes with the overflow flag set. Each frame passes through
// seven steps per sample in a single multiply-and-round sequence, then a final
// step that delivers the result before the controller returns to idle. The
// result sits in an output register, so the next frame is accepted while a
// result still waits to be taken; a result still waiting when the following
// frame is done keeps that frame in its final step and stalls the input until
// the waiting result is taken.
module pcm_dither_quantizer #(
  parameter int unsigned SAMPLE_FRAC_BITS = pdq_pkg::SAMPLE_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pdq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pdq_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  pdq_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output pdq_pkg::out_t                    out_data_o
);
  import pdq_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;
  out_t    res;
  out_t    out_q;
  logic    out_valid_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_format <= SAMPLE_FORMAT_RST;
      cfg_q.dither_enable <= DITHER_ENABLE_RST;
      cfg_q.gain          <= GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SAMPLE_FORMAT: cfg_q.sample_format <= cfg_wdata_i[0];
        REG_DITHER_ENABLE: cfg_q.dither_enable <= cfg_wdata_i[0];
        REG_GAIN:          cfg_q.gain          <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign status.out_free = !out_valid_q || !out_stall_i;

  pdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  pdq_datapath #(
    .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .cfg_i     (cfg_q),
    .in_data_i (in_data_i),
    .res_o     (res)
  );

  // Output register: load a finished frame, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.fin) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // A refused frame carries zero codes
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.size_overflow |->
      (out_data_o.left_code == '0) && (out_data_o.right_code == '0))
    else $error("refused frame with nonzero codes");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");
`endif

endmodule

### rtl/pdq_ctrl.sv
module pdq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  pdq_pkg::status_t status_i,
  output pdq_pkg::cmd_t    cmd_o,
  output logic             in_stall_o
);
  import pdq_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_SAT  = 4'd2;
  localparam logic [3:0] ST_ADD  = 4'd3;
  localparam logic [3:0] ST_PLO  = 4'd4;
  localparam logic [3:0] ST_PHI  = 4'd5;
  localparam logic [3:0] ST_SUM  = 4'd6;
  localparam logic [3:0] ST_RND  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       side_q, side_d;

  // Sequence left sample, then right, then hand the frame over
  always_comb begin
    state_d = state_q;
    side_d  = side_q;
    cmd_o   = '0;
    cmd_o.side = side_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          side_d     = 1'b0;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SAT;
      end
      ST_SAT: begin
        cmd_o.sat = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_PLO;
      end
      ST_PLO: begin
        cmd_o.plo = 1'b1;
        state_d   = ST_PHI;
      end
      ST_PHI: begin
        cmd_o.phi = 1'b1;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_RND;
      end
      ST_RND: begin
        cmd_o.rnd = 1'b1;
        if (side_q) begin
          state_d = ST_FIN;
        end else begin
          side_d  = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      side_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      side_q  <= side_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

`ifndef ASSERT_OFF
  // Stay idle until a transaction arrives
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && !in_valid_i |=> (state_q == ST_IDLE))
    else $error("controller left idle without a transaction");

  // The right sample is always rounded just before the frame is finished
  a_fin_after_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> side_q)
    else $error("frame finished before right sample");
`endif

endmodule

### rtl/pdq_datapath.sv
module pdq_datapath #(
  parameter int unsigned SAMPLE_FRAC_BITS = pdq_pkg::SAMPLE_FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pdq_pkg::cmd_t cmd_i,
  input  pdq_pkg::cfg_t cfg_i,
  input  pdq_pkg::in_t  in_data_i,
  output pdq_pkg::out_t res_o
);
  import pdq_pkg::*;

  localparam int unsigned SHIFT = 32 - SAMPLE_FRAC_BITS;
  localparam logic signed [56:0] SAT_POS = 57'sd1 <<< (SAMPLE_FRAC_BITS + 17);
  localparam logic signed [51:0] ONE_POS = 52'sd1 <<< 48;
  localparam logic [47:0]        HALF    = 48'd1 << 47;

  in_t                frame_q;
  logic [31:0]        noise_q;
  logic [31:0]        byte_count_q;
  logic signed [56:0] p_q;
  logic [23:0]        u1_q;
  logic signed [24:0] d_q;
  logic signed [51:0] ps_q;
  logic               neg_q;
  logic [48:0]        m_q;
  logic [46:0]        b_q;
  logic [47:0]        a_q;
  logic [47:0]        t_q;
  logic signed [23:0] left_code_q;
  logic signed [23:0] right_code_q;

  logic               is24;
  logic [22:0]        k;
  logic signed [31:0] sample;
  logic signed [56:0] prod;
  logic [31:0]        noise_next;
  logic signed [56:0] pc;
  logic signed [51:0] pc_w;
  logic signed [51:0] dx;
  logic signed [51:0] d_scaled;
  logic signed [51:0] w;
  logic signed [51:0] wc;
  logic signed [51:0] wabs;
  logic [23:0]        q;
  logic [47:0]        rem;
  logic               round_up;
  logic [23:0]        q1;
  logic signed [23:0] code;
  logic [2:0]         n_bytes;
  logic [32:0]        sum33;
  logic               over;

  assign is24       = cfg_i.sample_format;
  assign k          = is24 ? SCALE_24 : SCALE_16;
  assign sample     = cmd_i.side ? frame_q.right_sample : frame_q.left_sample;
  assign prod       = sample * $signed({1'b0, cfg_i.gain});
  assign noise_next = xs32(noise_q);

  // Saturate the product and move it to the Q48 working scale
  always_comb begin
    if (p_q > SAT_POS) begin
      pc = SAT_POS;
    end else if (p_q < -SAT_POS) begin
      pc = -SAT_POS;
    end else begin
      pc = p_q;
    end
    pc_w = pc[51:0];
  end

  // Add dither, clamp to plus or minus one and split off the sign
  always_comb begin
    dx       = {{27{d_q[24]}}, d_q};
    d_scaled = is24 ? (dx <<< 1) : (dx <<< 9);
    w        = ps_q + d_scaled;
    if (w > ONE_POS) begin
      wc = ONE_POS;
    end else if (w < -ONE_POS) begin
      wc = -ONE_POS;
    end else begin
      wc = w;
    end
    wabs = wc[51] ? -wc : wc;
  end

  // Round the scaled magnitude half to even
  always_comb begin
    q        = t_q[47:24];
    rem      = {t_q[23:0], b_q[23:0]};
    round_up = (rem > HALF) || ((rem == HALF) && q[0]);
    q1       = q + {23'd0, round_up};
    code     = neg_q ? -$signed(q1) : $signed(q1);
  end

  // Byte count guard
  always_comb begin
    n_bytes = is24 ? FRAME_BYTES_24 : FRAME_BYTES_16;
    sum33   = {1'b0, byte_count_q} + {30'd0, n_bytes};
    over    = sum33 > {1'b0, RIFF_DATA_LIMIT};
  end

  always_comb begin
    res_o.left_code     = over ? '0 : left_code_q;
    res_o.right_code    = over ? '0 : right_code_q;
    res_o.size_overflow = over;
    res_o.bytes_total   = over ? byte_count_q : sum33[31:0];
    res_o.last_out      = frame_q.last_in_block;
  end

  // Arithmetic pipeline, one step per controller strobe
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      frame_q <= in_data_i;
    end
    if (cmd_i.mul) begin
      p_q  <= prod;
      u1_q <= noise_next[31:8];
    end
    if (cmd_i.sat) begin
      ps_q <= pc_w <<< SHIFT;
      if (cfg_i.dither_enable) begin
        d_q <= $signed({1'b0, u1_q}) - $signed({1'b0, noise_next[31:8]});
      end else begin
        d_q <= '0;
      end
    end
    if (cmd_i.add) begin
      neg_q <= wc[51];
      m_q   <= wabs[48:0];
    end
    if (cmd_i.plo) begin
      b_q <= 47'(m_q[23:0]) * 47'(k);
    end
    if (cmd_i.phi) begin
      a_q <= 48'(m_q[48:24]) * 48'(k);
    end
    if (cmd_i.sum) begin
      t_q <= a_q + {25'd0, b_q[46:24]};
    end
    if (cmd_i.rnd) begin
      if (cmd_i.side) begin
        right_code_q <= code;
      end else begin
        left_code_q <= code;
      end
    end
  end

  // Advance the noise generator twice per sample while dithering
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q <= NOISE_SEED;
    end else if ((cmd_i.mul || cmd_i.sat) && cfg_i.dither_enable) begin
      noise_q <= noise_next;
    end
  end

  // Count accepted data bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
    end else if (cmd_i.fin && !over) begin
      byte_count_q <= sum33[31:0];
    end
  end

`ifndef ASSERT_OFF
  // A finished frame moves the count by zero or one frame size
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |=> (byte_count_q == $past(byte_count_q)) ||
                  (byte_count_q == $past(byte_count_q) + 32'd4) ||
                  (byte_count_q == $past(byte_count_q) + 32'd6))
    else $error("byte count moved by an invalid amount");

  // The count never passes the data size limit
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= RIFF_DATA_LIMIT)
    else $error("byte count past limit");
`endif

endmodule

### tb/sv/pdq_frame_checker.sv
`timescale 1ns / 1ps

module pdq_frame_checker #(
  parameter int unsigned FRAC_BITS = pdq_pkg::SAMPLE_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pdq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pdq_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  pdq_pkg::in_t                   in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  pdq_pkg::out_t                  out_data_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    frames_pending_o
);
  import pdq_pkg::*;

  localparam longint SatLimit  = longint'(1) << (FRAC_BITS + 17);
  localparam longint FullScale = longint'(1) << 48;
  localparam longint AlignMul  = longint'(1) << (32 - FRAC_BITS);
  localparam logic [47:0] HalfLsb = 48'h8000_0000_0000;

  // Shadow copy of the registers and of the block state
  logic        fmt24_q  = SAMPLE_FORMAT_RST;
  logic        dither_q = DITHER_ENABLE_RST;
  logic [23:0] gain_q   = GAIN_RST;
  logic [31:0] noise_q  = NOISE_SEED;
  logic [31:0] bytes_q  = '0;
  out_t        frames_due[$];
  int unsigned mismatches = 0;

  // Advance the noise generator and return its upper 24 bits
  function automatic longint noise_draw();
    noise_q = noise_q ^ (noise_q << 13);
    noise_q = noise_q ^ (noise_q >> 17);
    noise_q = noise_q ^ (noise_q << 5);
    return longint'(noise_q[31:8]);
  endfunction

  // Gain, dither, clamp and round one sample to a PCM code
  function automatic logic [23:0] quantize_code(input logic signed [31:0] smp);
    longint      work;
    longint      draw_a;
    longint      draw_b;
    logic        neg;
    logic [48:0] mag;
    logic [71:0] scaled;
    logic [23:0] code;
    work = longint'(smp) * longint'(gain_q);
    if (work > SatLimit) work = SatLimit;
    if (work < -SatLimit) work = -SatLimit;
    work = work * AlignMul;
    if (dither_q) begin
      draw_a = noise_draw();
      draw_b = noise_draw();
      work = work + (draw_a - draw_b) * (fmt24_q ? 64'sd2 : 64'sd512);
    end
    if (work > FullScale) work = FullScale;
    if (work < -FullScale) work = -FullScale;
    neg = work < 0;
    mag = neg ? 49'(-work) : 49'(work);
    scaled = 72'(mag) * 72'(fmt24_q ? SCALE_24 : SCALE_16);
    code = scaled[71:48];
    // round half to even on the dropped fraction
    if (scaled[47:0] > HalfLsb || (scaled[47:0] == HalfLsb && code[0])) begin
      code = code + 24'd1;
    end
    return neg ? -code : code;
  endfunction

  // Work out the result of one frame and update the byte count
  function automatic out_t predict_frame(input in_t frame);
    out_t        res;
    logic [32:0] grown;
    res.left_code  = quantize_code(frame.left_sample);
    res.right_code = quantize_code(frame.right_sample);
    grown = {1'b0, bytes_q} + 33'(fmt24_q ? FRAME_BYTES_24 : FRAME_BYTES_16);
    if (grown > {1'b0, RIFF_DATA_LIMIT}) begin
      res.left_code     = '0;
      res.right_code    = '0;
      res.size_overflow = 1'b1;
    end else begin
      res.size_overflow = 1'b0;
      bytes_q = grown[31:0];
    end
    res.bytes_total = bytes_q;
    res.last_out    = frame.last_in_block;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t: frame check: %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // Track register writes, compare results, queue predictions
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want;
    if (!rst_ni) begin
      fmt24_q  = SAMPLE_FORMAT_RST;
      dither_q = DITHER_ENABLE_RST;
      gain_q   = GAIN_RST;
      noise_q  = NOISE_SEED;
      bytes_q  = '0;
      frames_due.delete();
      frames_pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SAMPLE_FORMAT: fmt24_q = cfg_wdata_i[0];
          REG_DITHER_ENABLE: dither_q = cfg_wdata_i[0];
          REG_GAIN:          gain_q = cfg_wdata_i[23:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (frames_due.size() == 0) begin
          report_mismatch("result with no frame pending",
                          longint'(out_data_i.bytes_total), longint'(0));
        end else begin
          want = frames_due.pop_front();
          if (out_data_i.left_code !== want.left_code)
            report_mismatch("left_code", longint'(out_data_i.left_code),
                            longint'(want.left_code));
          if (out_data_i.right_code !== want.right_code)
            report_mismatch("right_code", longint'(out_data_i.right_code),
                            longint'(want.right_code));
          if (out_data_i.size_overflow !== want.size_overflow)
            report_mismatch("size_overflow", longint'(out_data_i.size_overflow),
                            longint'(want.size_overflow));
          if (out_data_i.bytes_total !== want.bytes_total)
            report_mismatch("bytes_total", longint'(out_data_i.bytes_total),
                            longint'(want.bytes_total));
          if (out_data_i.last_out !== want.last_out)
            report_mismatch("last_out", longint'(out_data_i.last_out),
                            longint'(want.last_out));
        end
      end
      // Queue the prediction for an accepted frame
      if (in_valid_i && !in_stall_i) begin
        frames_due = {frames_due, predict_frame(in_data_i)};
      end
      frames_pending_o <= frames_due.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

### tb/sv/pcm_dither_quantizer_tb.sv
`timescale 1ns / 1ps

module pcm_dither_quantizer_tb;
  import pdq_pkg::*;

  localparam int unsigned FRAC_BITS   = SAMPLE_FRAC_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 128;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic signed [31:0]   FULL_POS  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0]   HALF_POS  = FULL_POS >>> 1;
  localparam logic signed [31:0]   MAX_POS   = 32'sh7fff_ffff;
  localparam logic signed [31:0]   MAX_NEG   = 32'sh8000_0000;

  typedef enum int unsigned {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  int unsigned           fail_count;
  int unsigned           frames_pending;
  int unsigned           send_idle_pct = 0;
  int unsigned           stall_pct     = 0;
  int unsigned           holds_asked   = 0;
  int unsigned           holds_served  = 0;
  int unsigned           hold_left     = 0;
  int unsigned           cycle_count   = 0;

  always #5 clk = ~clk;

  pcm_dither_quantizer uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  pdq_frame_checker frame_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .fail_count_o     (fail_count),
    .frames_pending_o (frames_pending)
  );

  // Drive the result stall: a long hold-off when asked, random stalls otherwise
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall    <= 1'b0;
      hold_left    <= 0;
      holds_served <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_stall    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[pcm_dither_quantizer] ERROR");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_sample();
    logic signed [31:0] s;
    case ($urandom_range(4))
      0: s = $urandom();
      1: begin
        s = FULL_POS + $signed($urandom_range(8191)) - 32'sd4096;
        if ($urandom_range(1)) s = -s;
      end
      2: s = $signed($urandom_range(65535)) - 32'sd32768;
      3: s = $signed($urandom()) >>> $urandom_range(31);
      default: s = $signed($urandom()) >>> 4;
    endcase
    return s;
  endfunction

  function automatic logic [23:0] pick_gain();
    case ($urandom_range(5))
      0: return 24'd0;
      1: return 24'hff_ffff;
      2: return GAIN_RST;
      3: return 24'($urandom_range(262143, 16384));
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic set_idling(input idle_mode_e mode);
    send_idle_pct <= (mode == IDLE_SENDER) ? 88 : (mode == IDLE_BOTH) ? 15 : 0;
    stall_pct     <= (mode == IDLE_RECEIVER) ? 88 : (mode == IDLE_BOTH) ? 15 : 0;
  endtask

  // Offer one frame, after a random gap, and hold it until accepted
  task automatic send_frame(input logic signed [31:0] left, input logic signed [31:0] right,
                            input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= '{left_sample: left, right_sample: right, last_in_block: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Program all registers; optionally poke the unused index afterwards
  task automatic set_config(input logic fmt24, input logic dither, input logic [23:0] gain,
                            input bit spare);
    write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(fmt24));
    write_reg(REG_DITHER_ENABLE, CFG_DATA_W'(dither));
    write_reg(REG_GAIN, gain);
    if (spare) write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
    cfg_we <= 1'b0;
  endtask

  // Stop offering and wait until every transaction has come back
  task automatic drain_frames();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: 24-bit, no dither, unity gain
    send_frame(0, 0, 1'b0);
    send_frame(FULL_POS, -FULL_POS, 1'b1);
    send_frame(MAX_POS, MAX_NEG, 1'b0);
    send_frame(HALF_POS, -HALF_POS, 1'b1);
    send_frame(1, -1, 1'b0);
    send_frame(FULL_POS + 1, -FULL_POS - 1, 1'b1);
    drain_frames();

    // 16-bit with maximum gain, unused index poked
    set_config(1'b0, 1'b0, 24'hff_ffff, 1'b1);
    send_frame(MAX_POS, MAX_NEG, 1'b0);
    send_frame(1, -1, 1'b1);
    send_frame(HALF_POS, -HALF_POS, 1'b0);
    drain_frames();

    // 16-bit unity gain: half-LSB ties and clamping
    set_config(1'b0, 1'b0, GAIN_RST, 1'b0);
    send_frame(HALF_POS, -HALF_POS, 1'b1);
    send_frame(MAX_POS, MAX_NEG, 1'b0);
    drain_frames();

    // Zero gain with dither on, 24-bit
    set_config(1'b1, 1'b1, 24'd0, 1'b0);
    send_frame(MAX_POS, MAX_NEG, 1'b1);
    send_frame(0, 0, 1'b0);
    drain_frames();

    // Dither on, 16-bit, at zero, at full scale and at half scale
    set_config(1'b0, 1'b1, GAIN_RST, 1'b0);
    send_frame(0, 0, 1'b1);
    send_frame(FULL_POS, -FULL_POS, 1'b0);
    send_frame(HALF_POS, -HALF_POS, 1'b1);
    drain_frames();

    set_config(1'b1, 1'b1, GAIN_RST, 1'b1);
    send_frame(FULL_POS, -FULL_POS, 1'b0);
    send_frame(1, -1, 1'b1);

    // Random phases with a fresh setting and idling pattern each
    for (phase = 0; phase < PHASES; phase++) begin
      drain_frames();
      set_config(1'($urandom_range(1)), 1'($urandom_range(1)), pick_gain(), phase % 3 == 0);
      set_idling(idle_mode_e'(phase % 4));
      if (phase == 0) holds_asked <= holds_asked + 1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_frame(pick_sample(), pick_sample(), 1'($urandom_range(1)));
      end
    end
    drain_frames();

    if (fail_count == 0) begin
      $display("[pcm_dither_quantizer] OK");
    end else begin
      $display("[pcm_dither_quantizer] ERROR");
    end
    $finish;
  end

endmodule

### pcm_dither_quantizer.f
rtl/pdq_pkg.sv
rtl/pdq_ctrl.sv
rtl/pdq_datapath.sv
rtl/pcm_dither_quantizer.sv
tb/sv/pdq_frame_checker.sv
tb/sv/pcm_dither_quantizer_tb.sv
